FILE: hw/rtl/lrc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants for the Legendre recurrence coefficient block.
// ---------------------------------------------------------------------------
package lrc_pkg;

    localparam int MAX_DEGREE = 1023;
    localparam int FRAC_BITS  = 24;

    // field widths
    localparam int IDX_W   = 10;
    localparam int ACT_W   = 2;
    localparam int COEF_W  = 32;
    localparam int STAT_W  = 2;

    // arithmetic widths
    localparam int TERM_W  = 13;              // signed small factor
    localparam int PAIR_W  = 2 * TERM_W;      // product of two factors
    localparam int TRIP_W  = PAIR_W + TERM_W; // product of three factors
    localparam int MAG_W   = 34;              // |num|, |den| and divide remainder
    localparam int QUO_W   = 2 * COEF_W;      // saturated quotient, sqrt radicand
    localparam int ROOT_W  = QUO_W / 2;
    localparam int SHIFT   = 2 * FRAC_BITS + 2;   // 4^(FRAC_BITS+1)
    localparam int HI_SH   = QUO_W - SHIFT;       // numerator bits above the shift
    localparam int SQR_W   = ROOT_W + 2;          // sqrt remainder

    typedef enum logic [ACT_W-1:0] {
        ACT_A     = 2'd0,
        ACT_C     = 2'd1,
        ACT_INV_C = 2'd2,
        ACT_RATIO = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DIV = 2'd1,
        ST_NEG_RAD  = 2'd2
    } status_t;

    // side information that rides along the pipeline with each word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              neg;
        logic              ovf;
    } side_t;

endpackage : lrc_pkg
`default_nettype wire

FILE: hw/rtl/legendre_recurrence_coefficients.sv
`default_nettype none
// ---------------------------------------------------------------------------
// legendre_recurrence_coefficients
// Fixed-point coefficients of the normalized associated Legendre recurrence.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one word per request, tuser carries the action
//   (a, c, 1/c, -a/c), tdata the order m and degree l. Output stream m_*:
//   tdata is the coefficient, signed with 24 fraction bits rounded to
//   nearest, tuser the status (ok, zero divisor, negative radicand; the
//   coefficient is zero on error).
//   The magnitude is round(sqrt(N/D) * 2^24), exact: N/D is first turned
//   into floor(N * 2^50 / D) by a 64-stage restoring divider (one quotient
//   bit per stage), then a 32-stage integer square root (one root bit per
//   stage) gives s, and the rounded result is (s+1)/2.
//   Pipeline from accept to m_tvalid: two multiply stages, one range
//   check, 64 divide stages, 32 root stages, output register.
//   Throughput: one word per cycle unless stalled; stages hold a word each.
//   Stall: the whole pipeline freezes while m_tvalid is high and m_tready
//   low; s_tready drops then, nothing is lost or repeated.
//   Reset: all valid bits clear, the pipeline comes up empty.
// ---------------------------------------------------------------------------
module legendre_recurrence_coefficients
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [9:0] order, [19:10] degree, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] coefficient
    output logic [1:0]       m_tuser    // [1:0] status
);

    localparam int TW  = lrc_pkg::TERM_W;
    localparam int PW  = lrc_pkg::PAIR_W;
    localparam int XW  = lrc_pkg::TRIP_W;
    localparam int MW  = lrc_pkg::MAG_W;
    localparam int QW  = lrc_pkg::QUO_W;
    localparam int RW  = lrc_pkg::ROOT_W;
    localparam int SW  = lrc_pkg::SQR_W;
    localparam int IW  = lrc_pkg::IDX_W;
    localparam int CW  = lrc_pkg::COEF_W;
    localparam int NDIV = QW;
    localparam int NSQ  = RW;

    // global advance: everything moves unless a finished word is held
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: factors, status, first products -------------
    logic [IW-1:0] m_in, l_raw, l_in;
    lrc_pkg::action_t act;
    assign m_in  = s_tdata[IW-1:0];
    assign l_raw = s_tdata[2*IW-1:IW];
    assign l_in  = (32'(l_raw) > lrc_pkg::MAX_DEGREE) ? IW'(lrc_pkg::MAX_DEGREE) : l_raw;
    assign act   = lrc_pkg::action_t'(s_tuser);

    logic signed [TW-1:0] ls, ms;
    logic signed [TW-1:0] l2p3, l2p1, l2m1, lmm, lpm, lmm1, lpm1;
    assign ls   = TW'(signed'({1'b0, l_in}));
    assign ms   = TW'(signed'({1'b0, m_in}));
    assign l2p3 = TW'(2 * ls + 3);
    assign l2p1 = TW'(2 * ls + 1);
    assign l2m1 = TW'(2 * ls - 1);
    assign lmm  = ls - ms;
    assign lpm  = ls + ms;
    assign lmm1 = TW'(ls - ms + 1);
    assign lpm1 = TW'(ls + ms + 1);

    logic signed [TW-1:0] f1, f2, f3, g1, g2, g3;
    logic [lrc_pkg::STAT_W-1:0] st_c;
    logic neg_c, zero_c;
    logic l_zero, m_eq_l, m_eq_l1, m_gt_l, m_gt_l1;
    assign l_zero  = (l_in == '0);
    assign m_eq_l  = (m_in == l_in);
    assign m_eq_l1 = ({1'b0, m_in} == {1'b0, l_in} + 1'b1);
    assign m_gt_l  = (m_in > l_in);
    assign m_gt_l1 = ({1'b0, m_in} > {1'b0, l_in} + 1'b1);

    always_comb
    begin
        f1 = l2p3; f2 = l2p1; f3 = TW'(1);
        g1 = lmm1; g2 = lpm1; g3 = TW'(1);
        st_c   = lrc_pkg::ST_OK;
        neg_c  = 1'b0;
        zero_c = 1'b0;
        unique case (act)
            lrc_pkg::ACT_A:
            begin
                if (m_eq_l1)
                    st_c = lrc_pkg::ST_ZERO_DIV;
                else if (m_gt_l1)
                    st_c = lrc_pkg::ST_NEG_RAD;
            end
            lrc_pkg::ACT_C:
            begin
                f1 = l2p3; f2 = lmm;  f3 = lpm;
                g1 = l2m1; g2 = lpm1; g3 = lmm1;
                if (l_zero)
                    zero_c = 1'b1;
                else if (m_eq_l1)
                    st_c = lrc_pkg::ST_ZERO_DIV;
                else
                    neg_c = !m_gt_l;
            end
            lrc_pkg::ACT_INV_C:
            begin
                f1 = l2m1; f2 = lpm1; f3 = lmm1;
                g1 = l2p3; g2 = lpm;  g3 = lmm;
                if ((l_zero && m_in == '0) || m_eq_l || m_eq_l1)
                    st_c = lrc_pkg::ST_ZERO_DIV;
                else if (l_zero)
                    st_c = lrc_pkg::ST_NEG_RAD;
                else
                    neg_c = !m_gt_l;
            end
            lrc_pkg::ACT_RATIO:
            begin
                f1 = l2m1; f2 = l2p1; f3 = TW'(1);
                g1 = lmm;  g2 = lpm;  g3 = TW'(1);
                // 4l^2-1 is negative only at l = 0, l^2-m^2 only for m > l
                if (m_eq_l)
                    st_c = lrc_pkg::ST_ZERO_DIV;
                else if (l_zero != m_gt_l)
                    st_c = lrc_pkg::ST_NEG_RAD;
            end
            default: ;
        endcase
        if (st_c != lrc_pkg::ST_OK)
            zero_c = 1'b1;
    end

    logic                 v1_reg;
    logic signed [PW-1:0] p1_reg, q1_reg;
    logic signed [TW-1:0] f3_reg, g3_reg;
    logic                 zero1_reg;
    lrc_pkg::side_t       sd1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= PW'(f1) * PW'(f2);
            q1_reg    <= PW'(g1) * PW'(g2);
            f3_reg    <= f3;
            g3_reg    <= g3;
            zero1_reg <= zero_c;
            sd1_reg   <= '{status: st_c, neg: neg_c, ovf: 1'b0};
        end
    end

    // ---------------- stage 2: full products, magnitudes -------------------
    logic signed [XW-1:0] nprod, dprod;
    logic [XW-1:0] nabs, dabs;
    assign nprod = XW'(p1_reg) * XW'(f3_reg);
    assign dprod = XW'(q1_reg) * XW'(g3_reg);
    assign nabs  = nprod[XW-1] ? XW'(-nprod) : XW'(nprod);
    assign dabs  = dprod[XW-1] ? XW'(-dprod) : XW'(dprod);

    logic           v2_reg;
    logic [MW-1:0]  n2_reg, d2_reg;
    lrc_pkg::side_t sd2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // error or zero numerator: 0/1 gives a zero root
            n2_reg  <= zero1_reg ? '0 : nabs[MW-1:0];
            d2_reg  <= zero1_reg ? MW'(1) : dabs[MW-1:0];
            sd2_reg <= sd1_reg;
        end
    end

    // ---------------- stage 3: quotient range check, divider setup ---------
    // quotient N*2^SHIFT/D reaches 2^QW exactly when N >= D*2^HI_SH
    logic [MW+lrc_pkg::HI_SH-1:0] d_hi;
    assign d_hi = {d2_reg, {lrc_pkg::HI_SH{1'b0}}};

    logic           dv_vld [0:NDIV];
    logic [MW-1:0]  dv_rem [0:NDIV];
    logic [QW-1:0]  dv_w   [0:NDIV];
    logic [MW-1:0]  dv_d   [0:NDIV];
    lrc_pkg::side_t dv_sd  [0:NDIV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld[0] <= 1'b0;
        else if (en)
            dv_vld[0] <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem[0] <= MW'(n2_reg >> lrc_pkg::HI_SH);
            dv_w[0]   <= {n2_reg[lrc_pkg::HI_SH-1:0], {lrc_pkg::SHIFT{1'b0}}};
            dv_d[0]   <= d2_reg;
            dv_sd[0]  <= '{status: sd2_reg.status, neg: sd2_reg.neg,
                           ovf: ({{lrc_pkg::HI_SH{1'b0}}, n2_reg} >= d_hi)};
        end
    end

    // ---------------- divider: one quotient bit per stage ------------------
    // dv_w shifts dividend bits out at the top and quotient bits in below
    for (genvar k = 1; k <= NDIV; k++)
    begin : g_div
        logic [MW:0] t;
        logic        ge;
        assign t  = {dv_rem[k-1], dv_w[k-1][QW-1]};
        assign ge = (t >= {1'b0, dv_d[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld[k] <= 1'b0;
            else if (en)
                dv_vld[k] <= dv_vld[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem[k] <= ge ? MW'(t - {1'b0, dv_d[k-1]}) : MW'(t);
                dv_w[k]   <= {dv_w[k-1][QW-2:0], ge};
                dv_d[k]   <= dv_d[k-1];
                dv_sd[k]  <= dv_sd[k-1];
            end
        end
    end

    // ---------------- square root: one root bit per stage ------------------
    logic           sq_vld  [0:NSQ];
    logic [QW-1:0]  sq_f    [0:NSQ];
    logic [SW-1:0]  sq_rem  [0:NSQ];
    logic [RW-1:0]  sq_root [0:NSQ];
    lrc_pkg::side_t sq_sd   [0:NSQ];

    assign sq_vld[0]  = dv_vld[NDIV];
    assign sq_f[0]    = dv_w[NDIV];
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_sd[0]   = dv_sd[NDIV];

    for (genvar k = 1; k <= NSQ; k++)
    begin : g_sqrt
        logic [SW+1:0] t;
        logic [SW+1:0] trial;
        logic          ge;
        assign t     = {sq_rem[k-1], sq_f[k-1][QW-1:QW-2]};
        assign trial = (SW+2)'({sq_root[k-1], 2'b01});
        assign ge    = (t >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld[k] <= 1'b0;
            else if (en)
                sq_vld[k] <= sq_vld[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem[k]  <= ge ? SW'(t - trial) : SW'(t);
                sq_root[k] <= {sq_root[k-1][RW-2:0], ge};
                sq_f[k]    <= {sq_f[k-1][QW-3:0], 2'b00};
                sq_sd[k]   <= sq_sd[k-1];
            end
        end
    end

    // ---------------- output: rounding, sign, saturation -------------------
    // largest r with (2r-1)^2 <= floor(X) is (isqrt + 1) / 2
    logic [RW-1:0]  s_fin;
    logic [RW:0]    r_fin;
    logic [CW-1:0]  coef_next;
    lrc_pkg::side_t sd_fin;
    assign sd_fin = sq_sd[NSQ];
    assign s_fin  = sd_fin.ovf ? '1 : sq_root[NSQ];
    assign r_fin  = ({1'b0, s_fin} + 1'b1) >> 1;

    always_comb
    begin
        if (sd_fin.status != lrc_pkg::ST_OK)
            coef_next = '0;
        else if (sd_fin.neg)
            coef_next = CW'(-r_fin);
        else if (r_fin[RW-1:CW-1] != '0)
            coef_next = {1'b0, {(CW-1){1'b1}}};
        else
            coef_next = CW'(r_fin);
    end

    logic            out_vld_reg;
    logic [CW-1:0]   out_coef_reg;
    logic [1:0]      out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= sq_vld[NSQ];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_coef_reg <= coef_next;
            out_st_reg   <= sd_fin.status;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_coef_reg;
    assign m_tuser  = out_st_reg;

    // ---------------- assertions -------------------------------------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != lrc_pkg::ST_OK) |-> (m_tdata == '0))
        else $error("error status with nonzero coefficient");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (!en) |=> ($stable(dv_vld[NDIV]) && $stable(sq_vld[NSQ])))
        else $error("pipeline moved during stall");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_vld[NSQ] && sd_fin.ovf && sd_fin.status == lrc_pkg::ST_OK && en)
        |=> (m_tdata == 32'h7FFFFFFF || m_tdata == 32'h80000000))
        else $error("overflowed quotient not saturated");

endmodule : legendre_recurrence_coefficients
`default_nettype wire
